[rtl/wpm_pkg.sv]
// Shared types, constants and helpers of the wildcard pattern matcher.
package wpm_pkg;

  localparam int PAT_MAX = 64;
  localparam int LEN_W   = $clog2(PAT_MAX + 1);
  localparam int IDX_W   = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int ACT_W   = PAT_MAX + 1;
  localparam int LVLS    = (ACT_W > 1) ? $clog2(ACT_W) : 1;

  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_END     = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] char_code;
    logic       new_pattern;
  } in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]          len;
    logic                      ovf;
    logic [PAT_MAX-1:0][7:0]   bytes;
  } pat_t;

  typedef struct packed {
    logic       wr;
    logic       fresh;
    logic [7:0] ch;
  } pat_ctl_t;

  typedef struct packed {
    logic       restart;
    logic       step;
    logic [7:0] ch;
  } act_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CHAR_UA && c <= CHAR_UZ) begin
      r = c + CASE_DIFF;
    end
    return r;
  endfunction

endpackage

[rtl/wpm_pattern_store.sv]
// Pattern byte storage, pattern length and overflow flag.
module wpm_pattern_store (
  input  logic              clk,
  input  logic              rst,
  input  wpm_pkg::pat_ctl_t ctl,
  output wpm_pkg::pat_t     pat
);

  logic [wpm_pkg::LEN_W-1:0]        len;
  logic                             ovf;
  logic [wpm_pkg::PAT_MAX-1:0][7:0] bytes;
  logic [wpm_pkg::LEN_W-1:0]        len_base;
  logic                             room;

  always_comb begin
    len_base = ctl.fresh ? '0 : len;
    room     = len_base < wpm_pkg::LEN_W'(wpm_pkg::PAT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
    end else if (ctl.wr) begin
      if (room) begin
        len <= len_base + wpm_pkg::LEN_W'(1);
        ovf <= ctl.fresh ? 1'b0 : ovf;
      end else begin
        len <= len_base;
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && room) begin
      bytes[len_base[wpm_pkg::IDX_W-1:0]] <= ctl.ch;
    end
  end

  assign pat.len   = len;
  assign pat.ovf   = ovf;
  assign pat.bytes = bytes;

endmodule

[rtl/wpm_active_set.sv]
// Active position set with star closure and per-byte advance.
module wpm_active_set (
  input  logic              clk,
  input  logic              rst,
  input  logic              fold,
  input  wpm_pkg::pat_t     pat,
  input  wpm_pkg::act_ctl_t ctl,
  output logic              matched
);

  logic [wpm_pkg::ACT_W-1:0]   raw;
  logic [wpm_pkg::ACT_W-1:0]   raw_next;
  logic [wpm_pkg::ACT_W-1:0]   closed;
  logic [wpm_pkg::ACT_W-1:0]   prop;
  logic [wpm_pkg::ACT_W-1:0]   pg;
  logic [wpm_pkg::PAT_MAX-1:0] star;
  logic [wpm_pkg::PAT_MAX-1:0] hit;
  logic [7:0]                  tc;

  always_comb begin
    tc = wpm_pkg::fold_byte(ctl.ch, fold);
    for (int i = 0; i < wpm_pkg::PAT_MAX; i++) begin
      star[i] = (wpm_pkg::LEN_W'(i) < pat.len) && (pat.bytes[i] == wpm_pkg::CHAR_STAR);
      hit[i]  = (wpm_pkg::LEN_W'(i) < pat.len) && !star[i] &&
                ((pat.bytes[i] == wpm_pkg::CHAR_QMARK) ||
                 (wpm_pkg::fold_byte(pat.bytes[i], fold) == tc));
    end
  end

  // segmented prefix OR: a position inherits activity across a run of stars
  always_comb begin
    closed = raw;
    pg     = {star, 1'b0};
    for (int l = 0; l < wpm_pkg::LVLS; l++) begin
      closed = closed | (pg & (closed << (1 << l)));
      pg     = pg & (pg << (1 << l));
    end
    prop = {star, 1'b0};
  end

  always_comb begin
    raw_next = {1'b0, closed[wpm_pkg::PAT_MAX-1:0] & star} |
               {closed[wpm_pkg::PAT_MAX-1:0] & hit & ~prop[wpm_pkg::PAT_MAX:1], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw <= wpm_pkg::ACT_W'(1);
    end else if (ctl.restart) begin
      raw <= wpm_pkg::ACT_W'(1);
    end else if (ctl.step) begin
      raw <= raw_next;
    end
  end

  assign matched = closed[pat.len] && !pat.ovf;

endmodule

[rtl/wildcard_pattern_matcher.sv]
// Top level of the wildcard pattern matcher: input and result registers.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data (opcode, char_code, new_pattern)
//   out     | output    | out_valid/out_stall| out_data (matched, pattern_overflow)
//   cfg     | input     | cfg_wr_en          | cfg_wr_data (fold_case)
//
// One transaction per cycle while in_stall is low; an end-of-text transaction passes
// through the input register, then its result is captured in the result register.
// The active-set update and its star closure are combinational.
// Reset is synchronous; no clearing pass.
// An end-of-text transaction waits in the input register while the result
// register is full and stalled; other transactions keep flowing.
module wildcard_pattern_matcher (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  wpm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wpm_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);

  logic              in_q_valid;
  wpm_pkg::in_t      in_q;
  logic              fold;
  logic              eot_q;
  logic              adv;
  logic              matched;
  wpm_pkg::pat_t     pat;
  wpm_pkg::pat_ctl_t pat_ctl;
  wpm_pkg::act_ctl_t act_ctl;

  always_comb begin
    eot_q    = in_q.opcode == wpm_pkg::OP_END;
    in_stall = in_q_valid && eot_q && out_valid && out_stall;
    adv      = in_q_valid && !in_stall;

    pat_ctl.wr    = adv && (in_q.opcode == wpm_pkg::OP_PATTERN);
    pat_ctl.fresh = in_q.new_pattern;
    pat_ctl.ch    = in_q.char_code;

    act_ctl.restart = adv && ((in_q.opcode == wpm_pkg::OP_PATTERN) ||
                              (in_q.opcode == wpm_pkg::OP_END));
    act_ctl.step    = adv && (in_q.opcode == wpm_pkg::OP_TEXT);
    act_ctl.ch      = in_q.char_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold <= 1'b0;
    end else if (cfg_wr_en) begin
      fold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && eot_q) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && eot_q) begin
      out_data.matched          <= matched;
      out_data.pattern_overflow <= pat.ovf;
    end
  end

  wpm_pattern_store u_store (
    .clk (clk),
    .rst (rst),
    .ctl (pat_ctl),
    .pat (pat)
  );

  wpm_active_set u_active (
    .clk     (clk),
    .rst     (rst),
    .fold    (fold),
    .pat     (pat),
    .ctl     (act_ctl),
    .matched (matched)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_eot: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && eot_q && out_valid)
    else $error("input held without a blocked end-of-text transaction");

  a_eot_result: assert property (@(posedge clk) disable iff (rst)
    adv && eot_q |=> out_valid)
    else $error("end-of-text transaction produced no result");

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pattern_overflow |-> !out_data.matched)
    else $error("match reported on an overflowed pattern");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    pat.ovf |-> pat.len == wpm_pkg::LEN_W'(wpm_pkg::PAT_MAX))
    else $error("overflow flag set with pattern not full");
`endif

endmodule
